// ----- design/sha1_pkg.sv -----
// Shared types, constants and helpers for the SHA-1 digest block.
package sha1_pkg;

  localparam int unsigned NumRounds = 80;
  localparam int unsigned RndW      = 7;
  localparam int unsigned NumWords  = 16;
  localparam int unsigned NumChain  = 5;

  localparam logic [31:0] Iv0 = 32'h67452301;
  localparam logic [31:0] Iv1 = 32'hEFCDAB89;
  localparam logic [31:0] Iv2 = 32'h98BADCFE;
  localparam logic [31:0] Iv3 = 32'h10325476;
  localparam logic [31:0] Iv4 = 32'hC3D2E1F0;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [7:0] PadByte = 8'h80;

  localparam logic [2:0] LastIdx = 3'd4;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LEN,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } state_e;

  // What the block being compressed is
  typedef enum logic [1:0] {
    CMP_DATA,
    CMP_PAD1,
    CMP_FINAL
  } phase_e;

  // Datapath operations
  typedef enum logic [2:0] {
    DP_NOP,
    DP_BYTE,
    DP_PAD,
    DP_LEN,
    DP_ROUND,
    DP_ADD,
    DP_RESET
  } dp_op_e;

  // Round group selects f and K
  typedef enum logic [1:0] {
    GRP_CH,
    GRP_PAR0,
    GRP_MAJ,
    GRP_PAR1
  } grp_e;

  typedef struct packed {
    dp_op_e     op;
    grp_e       grp;
    logic [2:0] out_sel;
  } sha1_cmd_t;

  typedef struct packed {
    logic blk_full;  // next byte lands in the last slot of the block
    logic pad_two;   // padding spills into a second block
  } sha1_sts_t;

  function automatic logic [31:0] iv_word(input logic [2:0] idx);
    logic [31:0] v;
    case (idx)
      3'd0:    v = Iv0;
      3'd1:    v = Iv1;
      3'd2:    v = Iv2;
      3'd3:    v = Iv3;
      default: v = Iv4;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] round_k(input grp_e grp);
    logic [31:0] v;
    case (grp)
      GRP_CH:   v = K0;
      GRP_PAR0: v = K1;
      GRP_MAJ:  v = K2;
      default:  v = K3;
    endcase
    return v;
  endfunction

endpackage

// ----- design/sha1_ctrl.sv -----
// Controller state machine: sequences byte intake, padding, rounds and digest output.
module sha1_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                byte_present_i,
  input  logic                is_last_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [2:0]          word_index_o,
  output logic                last_word_o,
  input  sha1_pkg::sha1_sts_t sts_i,
  output sha1_pkg::sha1_cmd_t cmd_o
);

  localparam int unsigned RndW = sha1_pkg::RndW;

  sha1_pkg::state_e            state_q, state_d;
  sha1_pkg::phase_e            phase_q, phase_d;
  logic                        last_q, last_d;
  logic [sha1_pkg::RndW-1:0]   rnd_q, rnd_d;
  logic [2:0]                  idx_q, idx_d;

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sha1_pkg::ST_IDLE;
      phase_q <= sha1_pkg::CMP_DATA;
      last_q  <= 1'b0;
      rnd_q   <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      last_q  <= last_d;
      rnd_q   <= rnd_d;
      idx_q   <= idx_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d       = state_q;
    phase_d       = phase_q;
    last_d        = last_q;
    rnd_d         = rnd_q;
    idx_d         = idx_q;
    in_ready_o    = 1'b0;
    out_valid_o   = 1'b0;
    cmd_o.op      = sha1_pkg::DP_NOP;
    cmd_o.out_sel = idx_q;

    if (rnd_q < RndW'(20))      cmd_o.grp = sha1_pkg::GRP_CH;
    else if (rnd_q < RndW'(40)) cmd_o.grp = sha1_pkg::GRP_PAR0;
    else if (rnd_q < RndW'(60)) cmd_o.grp = sha1_pkg::GRP_MAJ;
    else                        cmd_o.grp = sha1_pkg::GRP_PAR1;

    case (state_q)
      sha1_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (byte_present_i) cmd_o.op = sha1_pkg::DP_BYTE;
          if (byte_present_i && sts_i.blk_full) begin
            last_d  = is_last_i;
            phase_d = sha1_pkg::CMP_DATA;
            rnd_d   = '0;
            state_d = sha1_pkg::ST_ROUND;
          end else if (is_last_i) begin
            state_d = sha1_pkg::ST_PAD;
          end
        end
      end
      sha1_pkg::ST_PAD: begin
        cmd_o.op = sha1_pkg::DP_PAD;
        phase_d  = sts_i.pad_two ? sha1_pkg::CMP_PAD1 : sha1_pkg::CMP_FINAL;
        rnd_d    = '0;
        state_d  = sha1_pkg::ST_ROUND;
      end
      sha1_pkg::ST_LEN: begin
        cmd_o.op = sha1_pkg::DP_LEN;
        phase_d  = sha1_pkg::CMP_FINAL;
        rnd_d    = '0;
        state_d  = sha1_pkg::ST_ROUND;
      end
      sha1_pkg::ST_ROUND: begin
        cmd_o.op = sha1_pkg::DP_ROUND;
        if (rnd_q == RndW'(sha1_pkg::NumRounds - 1)) begin
          rnd_d   = '0;
          state_d = sha1_pkg::ST_ADD;
        end else begin
          rnd_d = rnd_q + RndW'(1);
        end
      end
      sha1_pkg::ST_ADD: begin
        cmd_o.op = sha1_pkg::DP_ADD;
        case (phase_q)
          sha1_pkg::CMP_DATA: begin
            last_d  = 1'b0;
            state_d = last_q ? sha1_pkg::ST_PAD : sha1_pkg::ST_IDLE;
          end
          sha1_pkg::CMP_PAD1: state_d = sha1_pkg::ST_LEN;
          default: begin
            idx_d   = '0;
            state_d = sha1_pkg::ST_OUT;
          end
        endcase
      end
      sha1_pkg::ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (idx_q == sha1_pkg::LastIdx) begin
            cmd_o.op = sha1_pkg::DP_RESET;
            idx_d    = '0;
            state_d  = sha1_pkg::ST_IDLE;
          end else begin
            idx_d = idx_q + 3'd1;
          end
        end
      end
      default: state_d = sha1_pkg::ST_IDLE;
    endcase
  end

  assign word_index_o = idx_q;
  assign last_word_o  = (idx_q == sha1_pkg::LastIdx);

endmodule

// ----- design/sha1_dp.sv -----
// Datapath: block buffer, bit count, chaining value and the shared round unit.
module sha1_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [7:0]          data_byte_i,
  input  sha1_pkg::sha1_cmd_t cmd_i,
  output sha1_pkg::sha1_sts_t sts_o,
  output logic [31:0]         digest_word_o
);

  logic [31:0] blk_q   [sha1_pkg::NumWords];
  logic [31:0] chain_q [sha1_pkg::NumChain];
  logic [63:0] bitlen_q;
  logic [31:0] a_q, b_q, c_q, d_q, e_q;

  logic [5:0]  pos;
  logic [3:0]  wi;
  logic [4:0]  sh;
  logic [7:0]  put_val;
  logic [31:0] ins_word;
  logic [31:0] w_mix, w_new;
  logic [31:0] f_val, temp;

  // Byte placement within the block
  assign pos      = bitlen_q[8:3];
  assign wi       = pos[5:2];
  assign sh       = {~pos[1:0], 3'b000};
  assign put_val  = (cmd_i.op == sha1_pkg::DP_BYTE) ? data_byte_i : sha1_pkg::PadByte;
  assign ins_word = ((pos[1:0] == 2'b00) ? 32'h0 : blk_q[wi]) | ({24'h0, put_val} << sh);

  assign sts_o.blk_full = (pos == 6'd63);
  assign sts_o.pad_two  = (pos[5:3] == 3'b111);

  // Message schedule off the sliding window
  assign w_mix = blk_q[13] ^ blk_q[8] ^ blk_q[2] ^ blk_q[0];
  assign w_new = {w_mix[30:0], w_mix[31]};

  // Round function
  always_comb begin
    case (cmd_i.grp)
      sha1_pkg::GRP_CH:  f_val = (b_q & c_q) | (~b_q & d_q);
      sha1_pkg::GRP_MAJ: f_val = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
      default:           f_val = b_q ^ c_q ^ d_q;
    endcase
  end

  assign temp = {a_q[26:0], a_q[31:27]} + f_val + e_q + sha1_pkg::round_k(cmd_i.grp)
                + blk_q[0];

  // Update block buffer: byte insert, padding, length and schedule shift
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      sha1_pkg::DP_BYTE: blk_q[wi] <= ins_word;
      sha1_pkg::DP_PAD: begin
        for (int i = 0; i < sha1_pkg::NumWords; i++) begin
          if (4'(i) == wi) begin
            blk_q[i] <= ins_word;
          end else if (4'(i) > wi) begin
            if (!sts_o.pad_two && i == 14)      blk_q[i] <= bitlen_q[63:32];
            else if (!sts_o.pad_two && i == 15) blk_q[i] <= bitlen_q[31:0];
            else                                blk_q[i] <= 32'h0;
          end
        end
      end
      sha1_pkg::DP_LEN: begin
        for (int i = 0; i < sha1_pkg::NumWords; i++) begin
          if (i == 14)      blk_q[i] <= bitlen_q[63:32];
          else if (i == 15) blk_q[i] <= bitlen_q[31:0];
          else              blk_q[i] <= 32'h0;
        end
      end
      sha1_pkg::DP_ROUND: begin
        for (int i = 0; i < sha1_pkg::NumWords - 1; i++) blk_q[i] <= blk_q[i+1];
        blk_q[sha1_pkg::NumWords-1] <= w_new;
      end
      default: ;
    endcase
  end

  // Advance working variables; reload from the chaining value between blocks
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == sha1_pkg::DP_ROUND) begin
      a_q <= temp;
      b_q <= a_q;
      c_q <= {b_q[1:0], b_q[31:2]};
      d_q <= c_q;
      e_q <= d_q;
    end else begin
      a_q <= chain_q[0];
      b_q <= chain_q[1];
      c_q <= chain_q[2];
      d_q <= chain_q[3];
      e_q <= chain_q[4];
    end
  end

  // Hold chaining value and bit count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < sha1_pkg::NumChain; i++) chain_q[i] <= sha1_pkg::iv_word(3'(i));
      bitlen_q <= '0;
    end else begin
      case (cmd_i.op)
        sha1_pkg::DP_BYTE: bitlen_q[63:3] <= bitlen_q[63:3] + 61'd1;
        sha1_pkg::DP_ADD: begin
          chain_q[0] <= chain_q[0] + a_q;
          chain_q[1] <= chain_q[1] + b_q;
          chain_q[2] <= chain_q[2] + c_q;
          chain_q[3] <= chain_q[3] + d_q;
          chain_q[4] <= chain_q[4] + e_q;
        end
        sha1_pkg::DP_RESET: begin
          for (int i = 0; i < sha1_pkg::NumChain; i++) chain_q[i] <= sha1_pkg::iv_word(3'(i));
          bitlen_q <= '0;
        end
        default: ;
      endcase
    end
  end

  // Select digest word for output
  always_comb begin
    case (cmd_i.out_sel)
      3'd0:    digest_word_o = chain_q[0];
      3'd1:    digest_word_o = chain_q[1];
      3'd2:    digest_word_o = chain_q[2];
      3'd3:    digest_word_o = chain_q[3];
      default: digest_word_o = chain_q[4];
    endcase
  end

endmodule

// ----- design/sha1_message_digest.sv -----
// Top level: byte-serial SHA-1 digest, controller plus datapath.
// Message byte beats are taken while idle; the beat that fills a 64-byte block
// is followed by 80 rounds of the single round unit and one chaining add.
// A last beat adds a padding step and one compression (two, with a length block
// between, if padding spills), then five digest beats, one per cycle at best.
// Reset (asynchronous, active low) loads the initial hash, clears the bit count
// and idles the controller; the buffer needs no clearing.
module sha1_message_digest (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_present_i,
  input  logic        is_last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  sha1_pkg::sha1_cmd_t cmd;
  sha1_pkg::sha1_sts_t sts;

  sha1_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .byte_present_i (byte_present_i),
    .is_last_i      (is_last_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .word_index_o   (word_index_o),
    .last_word_o    (last_word_o),
    .sts_i          (sts),
    .cmd_o          (cmd)
  );

  sha1_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .data_byte_i   (data_byte_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .digest_word_o (digest_word_o)
  );

endmodule

// ----- design/sha1_checker.sv -----
// Port-level checker for the SHA-1 digest block, bound to the top level.
module sha1_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [7:0]  data_byte_i,
  input logic        byte_present_i,
  input logic        is_last_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] digest_word_o,
  input logic [2:0]  word_index_o,
  input logic        last_word_o
);

  // Stalled output beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(digest_word_o)
      && $stable(word_index_o))
    else $error("stalled digest beat changed");

  // Input is not taken while the digest drains
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input ready during digest output");

  // Last flag marks the fifth word only
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_word_o == (word_index_o == 3'd4)) && (word_index_o <= 3'd4))
    else $error("bad word index or last flag");

  // Words advance one by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_word_o |=>
      out_valid_o && (word_index_o == $past(word_index_o) + 3'd1))
    else $error("digest words out of order");

  // Output stops after the final word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && last_word_o |=> !out_valid_o && in_ready_o)
    else $error("output did not end after final word");

endmodule

bind sha1_message_digest sha1_checker u_sha1_checker (.*);

// ----- sim/tb_sha1_message_digest.sv -----
// Testbench for the byte-serial SHA-1 digest block: random messages against a local digest model.
`timescale 1ns / 1ps

module tb_sha1_message_digest;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_beat_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  data_byte_i;
  logic        byte_present_i;
  logic        is_last_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [31:0] digest_word_o;
  logic [2:0]  word_index_o;
  logic        last_word_o;

  // Digest model state
  logic [31:0] chain_q [sha1_pkg::NumChain];
  logic [31:0] blk_q   [sha1_pkg::NumWords];
  logic [63:0] nbits_q;

  digest_beat_t expected_digest_q [$];

  int unsigned mismatch_count;
  int unsigned msg_bytes_sent;
  int unsigned sender_idle_pct;
  int unsigned receiver_stall_pct;
  int unsigned hold_req;
  int unsigned hold_left;

  sha1_message_digest DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .byte_present_i (byte_present_i),
    .is_last_i      (is_last_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .digest_word_o  (digest_word_o),
    .word_index_o   (word_index_o),
    .last_word_o    (last_word_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Report one mismatch and count it
  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $realtime, what);
    mismatch_count++;
  endtask

  function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned s);
    return (v << s) | (v >> (32 - s));
  endfunction

  function automatic void reset_digest_model();
    chain_q[0] = sha1_pkg::Iv0;
    chain_q[1] = sha1_pkg::Iv1;
    chain_q[2] = sha1_pkg::Iv2;
    chain_q[3] = sha1_pkg::Iv3;
    chain_q[4] = sha1_pkg::Iv4;
    for (int i = 0; i < sha1_pkg::NumWords; i++) blk_q[i] = '0;
    nbits_q = '0;
  endfunction

  // Run the 80 rounds over the buffered block and fold into the chain
  function automatic void compress_block();
    logic [31:0] w [sha1_pkg::NumRounds];
    logic [31:0] a, b, c, d, e, f, k, sum;
    for (int t = 0; t < sha1_pkg::NumWords; t++) w[t] = blk_q[t];
    for (int t = sha1_pkg::NumWords; t < sha1_pkg::NumRounds; t++)
      w[t] = rotl(w[t-3] ^ w[t-8] ^ w[t-14] ^ w[t-16], 1);
    a = chain_q[0];
    b = chain_q[1];
    c = chain_q[2];
    d = chain_q[3];
    e = chain_q[4];
    for (int t = 0; t < sha1_pkg::NumRounds; t++) begin
      if (t < 20) begin
        f = (b & c) | (~b & d);
        k = sha1_pkg::K0;
      end else if (t < 40) begin
        f = b ^ c ^ d;
        k = sha1_pkg::K1;
      end else if (t < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = sha1_pkg::K2;
      end else begin
        f = b ^ c ^ d;
        k = sha1_pkg::K3;
      end
      sum = rotl(a, 5) + f + e + k + w[t];
      e = d;
      d = c;
      c = rotl(b, 30);
      b = a;
      a = sum;
    end
    chain_q[0] += a;
    chain_q[1] += b;
    chain_q[2] += c;
    chain_q[3] += d;
    chain_q[4] += e;
  endfunction

  // Drop a byte into the block; the first byte of a word clears it
  function automatic void place_byte(input int unsigned pos, input logic [7:0] b);
    int unsigned wi;
    int unsigned sh;
    wi = (pos >> 2) & 15;
    sh = (3 - (pos & 3)) * 8;
    if ((pos & 3) == 0) blk_q[wi] = '0;
    blk_q[wi] |= 32'(b) << sh;
  endfunction

  // Advance the model by one accepted beat and queue any digest words
  function automatic void absorb_beat(input logic [7:0] d, input logic p, input logic l);
    int unsigned pos;
    digest_beat_t r;
    if (p) begin
      pos = {26'd0, nbits_q[8:3]};
      place_byte(pos, d);
      nbits_q += 64'd8;
      if (pos == 63) compress_block();
    end
    if (l) begin
      pos = {26'd0, nbits_q[8:3]};
      place_byte(pos, sha1_pkg::PadByte);
      for (int i = (pos >> 2) + 1; i < sha1_pkg::NumWords; i++) blk_q[i] = '0;
      if (pos >= 56) begin
        compress_block();
        for (int i = 0; i < sha1_pkg::NumWords; i++) blk_q[i] = '0;
      end
      blk_q[14] = nbits_q[63:32];
      blk_q[15] = nbits_q[31:0];
      compress_block();
      for (int i = 0; i < sha1_pkg::NumChain; i++) begin
        r.word  = chain_q[i];
        r.index = 3'(i);
        r.last  = (3'(i) == sha1_pkg::LastIdx);
        expected_digest_q.push_back(r);
      end
      reset_digest_model();
    end
  endfunction

  // Send one beat; enter and leave at a falling edge
  task automatic send_beat(input logic [7:0] d, input logic p, input logic l);
    while (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    data_byte_i    <= d;
    byte_present_i <= p;
    is_last_i      <= l;
    do @(posedge clk_i); while (!in_ready_o);
    absorb_beat(d, p, l);
    if (p) msg_bytes_sent++;
    @(negedge clk_i);
  endtask

  // One message of len bytes; optionally ends on its last byte, optionally with idle beats
  task automatic send_message(input int unsigned len, input bit end_on_byte, input bit noise);
    for (int unsigned i = 0; i < len; i++) begin
      if (noise && $urandom_range(0, 7) == 0)
        send_beat(8'($urandom), 1'b0, 1'b0);
      send_beat(8'($urandom), 1'b1, (end_on_byte && i == len - 1) ? 1'b1 : 1'b0);
    end
    if (len == 0 || !end_on_byte)
      send_beat(8'($urandom), 1'b0, 1'b1);
  endtask

  // Mostly short messages, some reaching the padding boundaries
  task automatic run_random_traffic(input int unsigned beats);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned len;
    stop_at = msg_bytes_sent + beats;
    while (msg_bytes_sent < stop_at) begin
      pick = $urandom_range(0, 19);
      if (pick < 13)      len = $urandom_range(0, 9);
      else if (pick < 16) len = $urandom_range(10, 40);
      else if (pick < 19) len = $urandom_range(54, 65);
      else                len = 0;
      if (pick == 19) begin
        // stray idle beats between messages
        repeat ($urandom_range(1, 4)) send_beat(8'($urandom), 1'b0, 1'b0);
      end else begin
        send_message(len, $urandom_range(0, 1), 1'b1);
      end
    end
  endtask

  task automatic test_directed_cases();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    // empty message
    send_beat(8'h00, 1'b0, 1'b1);
    // "abc", last flag on the final byte
    send_beat(8'h61, 1'b1, 1'b0);
    send_beat(8'h62, 1'b1, 1'b0);
    send_beat(8'h63, 1'b1, 1'b1);
    // idle beats with extreme data are ignored
    send_beat(8'hFF, 1'b0, 1'b0);
    send_beat(8'h00, 1'b0, 1'b0);
    // single-byte messages at the data extremes
    send_beat(8'hFF, 1'b1, 1'b1);
    send_beat(8'h00, 1'b1, 1'b1);
    // byte, idle beat, byte, then end without a byte
    send_beat(8'hA5, 1'b1, 1'b0);
    send_beat(8'h5A, 1'b0, 1'b0);
    send_beat(8'h3C, 1'b1, 1'b0);
    send_beat(8'hFF, 1'b0, 1'b1);
    // back-to-back empty messages
    send_beat(8'hFF, 1'b0, 1'b1);
    send_beat(8'h00, 1'b0, 1'b1);
  endtask

  // Padding lands at 55 (one block), 56 (two blocks), and on a fresh block
  task automatic test_pad_boundaries();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    send_message(55, 1'b0, 1'b0);
    send_message(56, 1'b1, 1'b0);
    send_message(64, 1'b1, 1'b0);
  endtask

  task automatic test_no_idling();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    run_random_traffic(15);
  endtask

  task automatic test_sender_idle();
    sender_idle_pct    = 77;
    receiver_stall_pct = 0;
    run_random_traffic(15);
  endtask

  task automatic test_receiver_stall();
    sender_idle_pct    = 0;
    receiver_stall_pct = 77;
    run_random_traffic(15);
  endtask

  task automatic test_both_idle();
    sender_idle_pct    = 15;
    receiver_stall_pct = 15;
    run_random_traffic(15);
  endtask

  // Hold the receiver off while messages keep coming so the input stalls
  task automatic test_output_backpressure();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    hold_req = 600;
    repeat (4) send_message($urandom_range(1, 4), $urandom_range(0, 1), 1'b0);
  endtask

  // Drive the receiver ready, with long hold-offs on request
  always @(negedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left--;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end
  end

  // Compare each accepted digest beat with the oldest expectation
  always @(posedge clk_i) begin
    digest_beat_t exp_beat;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_digest_q.size() == 0) begin
        report_mismatch($sformatf("unexpected digest beat word=%h index=%0d last=%b",
                                  digest_word_o, word_index_o, last_word_o));
      end else begin
        exp_beat = expected_digest_q.pop_front();
        if (digest_word_o !== exp_beat.word)
          report_mismatch($sformatf("digest_word %h, expected %h (index %0d)",
                                    digest_word_o, exp_beat.word, exp_beat.index));
        if (word_index_o !== exp_beat.index)
          report_mismatch($sformatf("word_index %0d, expected %0d",
                                    word_index_o, exp_beat.index));
        if (last_word_o !== exp_beat.last)
          report_mismatch($sformatf("last_word %b, expected %b (index %0d)",
                                    last_word_o, exp_beat.last, exp_beat.index));
      end
    end
  end

  initial begin
    #4_000_000;
    $display("sha1_message_digest verification failed");
    $finish;
  end

  initial begin
    int unsigned waited;
    rst_ni             = 1'b0;
    in_valid_i         = 1'b0;
    data_byte_i        = '0;
    byte_present_i     = 1'b0;
    is_last_i          = 1'b0;
    out_ready_i        = 1'b0;
    mismatch_count     = 0;
    msg_bytes_sent     = 0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    hold_req           = 0;
    hold_left          = 0;
    reset_digest_model();
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed_cases();
    test_pad_boundaries();
    test_no_idling();
    test_sender_idle();
    test_receiver_stall();
    test_both_idle();
    test_output_backpressure();

    // Stop offering and drain the digest beats
    in_valid_i         <= 1'b0;
    receiver_stall_pct = 0;
    waited = 0;
    while (expected_digest_q.size() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    if (expected_digest_q.size() != 0) begin
      $display("sha1_message_digest verification failed");
      $finish;
    end else begin
      repeat (200) @(posedge clk_i);
      if (expected_digest_q.size() != 0)
        report_mismatch($sformatf("%0d digest beats never arrived",
                                  expected_digest_q.size()));
      if (mismatch_count == 0) begin
        $display("sha1_message_digest verification clean");
      end else begin
        $display("sha1_message_digest verification failed");
      end
      $finish;
    end
  end

endmodule
